// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DATA_W = 32;
  localparam int PRIO_W = 8;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [DATA_W-1:0]   item_data;
    logic [PRIO_W-1:0]   item_priority;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   head_data;
  } rsp_t;

  typedef struct packed {
    logic                ins;
    logic                rem;
    logic [PRIO_W-1:0]   prio;
    logic [DATA_W-1:0]   data;
  } cell_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occupied,
  input  logic              left_le,
  input  logic [PRIO_W-1:0] left_prio,
  input  logic [DATA_W-1:0] left_data,
  input  logic [PRIO_W-1:0] right_prio,
  input  logic [DATA_W-1:0] right_data,
  output logic [PRIO_W-1:0] prio,
  output logic [DATA_W-1:0] data,
  output logic              le
);

  logic [PRIO_W-1:0] prio_next;
  logic [DATA_W-1:0] data_next;

  // An occupied entry that sorts at or before the new item stays in place.
  assign le = occupied && (prio <= ctl.prio);

  always_comb begin
    prio_next = prio;
    data_next = data;
    if (ctl.ins && !le) begin
      if (left_le) begin
        prio_next = ctl.prio;
        data_next = ctl.data;
      end else begin
        prio_next = left_prio;
        data_next = left_data;
      end
    end else if (ctl.rem) begin
      prio_next = right_prio;
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    data <= data_next;
  end

endmodule

// ===== sv/stable_min_priority_queue.sv =====
`timescale 1ns / 1ps

// Sorted priority queue built as a row of slot cells, head in the first cell.
// A request is taken on a rising edge with start high and busy low. busy stays
// low, so one request is accepted in every cycle. kind selects insert, remove
// or peek; insert places the item behind all entries of lower or equal
// priority value, so equal priorities leave in arrival order.
// Every request gives one result on the cycle after it is accepted: done is
// high for exactly that cycle with result holding status and, for a remove or
// peek on a non-empty queue, the head data. Throughput is one request per cycle,
// set by the parallel compare in every cell and the one-step shift to a neighbor.
// Insert into a full queue reports full and changes nothing; remove or peek on
// an empty queue reports empty. Results cannot be stalled by the receiver.
// Synchronous reset empties the queue and clears done; slot contents are left
// as they are and are never read before they are written.
module stable_min_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic [OCC_W-1:0]  occupancy;
  logic [OCC_W-1:0]  occupancy_next;
  rsp_t              result_next;
  cell_ctl_t         ctl;
  logic              accept;
  logic              full;
  logic              empty;

  logic [PRIO_W-1:0] slot_prio [CAPACITY];
  logic [DATA_W-1:0] slot_data [CAPACITY];
  logic              slot_le   [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (occupancy == OCC_W'(CAPACITY));
  assign empty  = (occupancy == '0);

  always_comb begin
    ctl.ins          = 1'b0;
    ctl.rem          = 1'b0;
    ctl.prio         = request.item_priority;
    ctl.data         = request.item_data;
    occupancy_next   = occupancy;
    result_next      = '{status: ST_DONE, head_data: '0};
    if (accept) begin
      unique case (request.kind)
        KIND_INSERT: begin
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            ctl.ins        = 1'b1;
            occupancy_next = occupancy + OCC_W'(1);
          end
        end
        KIND_REMOVE, KIND_PEEK: begin
          if (empty) begin
            result_next.status = ST_EMPTY;
          end else begin
            result_next.head_data = slot_data[0];
            if (request.kind == KIND_REMOVE) begin
              ctl.rem        = 1'b1;
              occupancy_next = occupancy - OCC_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              left_le;
    logic [PRIO_W-1:0] left_prio;
    logic [DATA_W-1:0] left_data;
    logic [PRIO_W-1:0] right_prio;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_le   = 1'b1;
      assign left_prio = slot_prio[0];
      assign left_data = slot_data[0];
    end else begin : g_inner
      assign left_le   = slot_le[i-1];
      assign left_prio = slot_prio[i-1];
      assign left_data = slot_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_prio = slot_prio[i];
      assign right_data = slot_data[i];
    end else begin : g_body
      assign right_prio = slot_prio[i+1];
      assign right_data = slot_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (OCC_W'(i) < occupancy),
      .left_le    (left_le),
      .left_prio  (left_prio),
      .left_data  (left_data),
      .right_prio (right_prio),
      .right_data (right_data),
      .prio       (slot_prio[i]),
      .data       (slot_data[i]),
      .le         (slot_le[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      done      <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      done      <= accept;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(CAPACITY))
    else $error("occupancy exceeds capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request produced no result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && request.kind == KIND_INSERT && full |=>
      result.status == ST_FULL && $stable(occupancy))
    else $error("insert into full queue changed state");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(occupancy))
    else $error("occupancy changed without a request");
`endif

endmodule
